// ----- sv/assert_macros.svh -----
// Assertion helper macros for the steering core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, masked while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mltps_pkg.sv -----
// Shared types and constants for the magnetic line tracker steering core.
// No dependencies.
package mltps_pkg;

	// Sensor strip geometry
	localparam int SENSOR_BITS = 16;
	localparam int POS_W       = $clog2(SENSOR_BITS);
	localparam int CNT_W       = $clog2(2 * SENSOR_BITS + 1);
	localparam int CENTER_POS  = 7;

	// Count thresholds and reported count width
	localparam int VC_W        = 5;
	localparam int VC_MAX      = (1 << VC_W) - 1;
	localparam int FOUND_MIN   = 1;
	localparam int TURN_MIN    = 5;

	// PD term and drive limits
	localparam int PD_MIN_SPEED = 10;
	localparam int DRIVE_W      = 15;
	localparam int DRIVE_MAX    = (1 << (DRIVE_W - 1)) - 1;
	localparam int DRIVE_MIN    = -(1 << (DRIVE_W - 1));

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED  = 3'd0,
		REG_RATIO  = 3'd1,
		REG_SETPT  = 3'd2,
		REG_PGAIN  = 3'd3,
		REG_DGAIN  = 3'd4
	} reg_idx_t;

	// Input word kinds
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_MOTION = 1'b1
	} opcode_t;

	// Turn mode; a command code of 3 is stored as forward
	typedef enum logic [1:0] {
		MODE_LEFT    = 2'd0,
		MODE_RIGHT   = 2'd1,
		MODE_FORWARD = 2'd2
	} turn_mode_t;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

endpackage

// ----- sv/magnetic_line_tracker_pd_steer_core.sv -----
// Steering core for a magnetic strip line follower: input and result registers
// around a single pass of scan, point choice and PD arithmetic.
// Depends on mltps_pkg and assert_macros.svh.
//
// One word is taken every clock cycle while the result side keeps up; each
// word gives exactly one result word, which passes through the input register
// and then the result register (one input register, one result register).
// Rate is set only by out_stall: the result register and the input register
// each hold one word, so a new word is taken while a finished result waits.
// Sensor words are scanned for adjacent set-bit pairs; when the count exceeds
// one the drives are updated from base duty (speed * ratio) plus and minus a
// PD term that is active from speed 10.
// Motion command words set the turn mode and give an all-zero result.
// Configuration may be written only while no word is in flight.

`include "assert_macros.svh"

module magnetic_line_tracker_pd_steer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write_en,
	input  logic [mltps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mltps_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [mltps_pkg::SENSOR_BITS-1:0] sensor_word,
	input  logic [1:0]                        motion_command,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              track_found,
	output logic signed [mltps_pkg::DRIVE_W-1:0] left_drive,
	output logic signed [mltps_pkg::DRIVE_W-1:0] right_drive,
	output logic                              turn_done,
	output logic [mltps_pkg::VC_W-1:0]        valid_count
);
	import mltps_pkg::*;

	// Configuration registers
	logic [6:0] speed_q;
	logic [6:0] ratio_q;
	logic [3:0] setpt_q;
	logic [7:0] pgain_q;
	logic [7:0] dgain_q;

	// Block state
	turn_mode_t        turn_mode_q, turn_mode_d;
	logic              turn_finished_q, turn_finished_d;
	logic signed [7:0] prev_dev_q, prev_dev_d;

	// Input register
	logic                   valid_s1;
	logic                   opcode_s1;
	logic [SENSOR_BITS-1:0] sensor_s1;
	logic [1:0]             cmd_s1;

	// Result register
	logic                      out_valid_q;
	logic                      found_q;
	logic signed [DRIVE_W-1:0] left_q;
	logic signed [DRIVE_W-1:0] right_q;
	logic                      done_q;
	logic [VC_W-1:0]           count_q;

	// Handshake
	logic out_ready;
	logic adv_s1;
	logic in_take;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_take   = in_valid && !in_stall;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 7'd3;
			ratio_q <= 7'd1;
			setpt_q <= 4'd7;
			pgain_q <= 8'd0;
			dgain_q <= 8'd0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_SPEED: speed_q <= cfg_data[6:0];
				REG_RATIO: ratio_q <= cfg_data[6:0];
				REG_SETPT: setpt_q <= cfg_data[3:0];
				REG_PGAIN: pgain_q <= cfg_data;
				REG_DGAIN: dgain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode;
			sensor_s1 <= sensor_word;
			cmd_s1    <= motion_command;
		end
	end

	// Pair map: bit i set when sensor bits i and i+1 are both set
	logic [SENSOR_BITS-1:0] pair_c;
	always_comb begin
		pair_c = '0;
		for (int i = 0; i < SENSOR_BITS - 1; i++) begin
			pair_c[i] = sensor_s1[i] & sensor_s1[i+1];
		end
	end

	// Pair count plus run ends (a run reaching the top bit also has its end counted)
	logic [CNT_W-1:0] count_c;
	always_comb begin
		count_c = '0;
		for (int i = 0; i < SENSOR_BITS; i++) begin
			count_c = count_c + CNT_W'(pair_c[i]);
		end
		for (int i = 0; i < SENSOR_BITS - 1; i++) begin
			count_c = count_c + CNT_W'(pair_c[i] & ~pair_c[i+1]);
		end
	end

	// Lowest, highest and nearest-to-centre pair positions
	logic [POS_W-1:0] lo_c, hi_c, near_c;
	always_comb begin
		lo_c   = POS_W'(SENSOR_BITS - 1);
		hi_c   = '0;
		near_c = POS_W'(CENTER_POS);
		for (int i = SENSOR_BITS - 1; i >= 0; i--) begin
			if (pair_c[i]) lo_c = POS_W'(i);
		end
		for (int i = 0; i < SENSOR_BITS; i++) begin
			if (pair_c[i]) hi_c = POS_W'(i);
		end
		// widest distance first so the closest wins; lower side last on a tie
		for (int d = SENSOR_BITS - 1; d >= 0; d--) begin
			if (CENTER_POS + d < SENSOR_BITS) begin
				if (pair_c[CENTER_POS + d]) near_c = POS_W'(CENTER_POS + d);
			end
			if (d <= CENTER_POS) begin
				if (pair_c[CENTER_POS - d]) near_c = POS_W'(CENTER_POS - d);
			end
		end
	end

	// Point choice and turn state
	logic             found_c;
	logic             done_c;
	logic [POS_W-1:0] point_c;
	always_comb begin
		found_c         = count_c > CNT_W'(FOUND_MIN);
		done_c          = 1'b0;
		point_c         = near_c;
		turn_mode_d     = turn_mode_q;
		turn_finished_d = turn_finished_q;
		if (opcode_s1 == OP_MOTION) begin
			found_c = 1'b0;
			if (cmd_s1 == CMD_UNUSED) begin
				turn_mode_d = MODE_FORWARD;
			end else begin
				turn_mode_d = turn_mode_t'(cmd_s1);
			end
		end else if (found_c) begin
			if (count_c > CNT_W'(TURN_MIN)) begin
				turn_finished_d = 1'b1;
				case (turn_mode_q)
					MODE_LEFT:  point_c = hi_c;
					MODE_RIGHT: point_c = lo_c;
					default:    point_c = near_c;
				endcase
			end else if (turn_finished_q) begin
				turn_finished_d = 1'b0;
				turn_mode_d     = MODE_FORWARD;
				done_c          = 1'b1;
			end
		end
	end

	// PD term
	logic              pd_on_c;
	logic signed [7:0]  dev_c, ddev_c;
	logic signed [16:0] p_term_c, d_term_c;
	logic signed [17:0] pd_sum_c;
	logic signed [15:0] pd_c;
	always_comb begin
		pd_on_c  = speed_q >= 7'(PD_MIN_SPEED);
		dev_c    = 8'(setpt_q) - 8'(point_c);
		ddev_c   = dev_c - prev_dev_q;
		p_term_c = $signed({1'b0, pgain_q}) * dev_c;
		d_term_c = $signed({1'b0, dgain_q}) * ddev_c;
		pd_sum_c = 18'(p_term_c) + 18'(d_term_c);
		pd_c     = pd_on_c ? pd_sum_c[15:0] : 16'sd0;
		prev_dev_d = (opcode_s1 == OP_SAMPLE && found_c && pd_on_c) ? dev_c : prev_dev_q;
	end

	// Base duty and saturated drives
	logic [13:0]               duty_full_c;
	logic signed [7:0]         duty_c;
	logic signed [16:0]        left_sum_c, right_sum_c;
	logic signed [DRIVE_W-1:0] left_c, right_c;
	always_comb begin
		duty_full_c = speed_q * ratio_q;
		duty_c      = duty_full_c[7:0];
		left_sum_c  = 17'(duty_c) + 17'(pd_c);
		right_sum_c = 17'(duty_c) - 17'(pd_c);
		if (left_sum_c > 17'(DRIVE_MAX)) begin
			left_c = DRIVE_W'(DRIVE_MAX);
		end else if (left_sum_c < 17'(DRIVE_MIN)) begin
			left_c = DRIVE_W'(DRIVE_MIN);
		end else begin
			left_c = left_sum_c[DRIVE_W-1:0];
		end
		if (right_sum_c > 17'(DRIVE_MAX)) begin
			right_c = DRIVE_W'(DRIVE_MAX);
		end else if (right_sum_c < 17'(DRIVE_MIN)) begin
			right_c = DRIVE_W'(DRIVE_MIN);
		end else begin
			right_c = right_sum_c[DRIVE_W-1:0];
		end
	end

	// Reported count, saturated
	logic [VC_W-1:0] vcount_c;
	assign vcount_c = (count_c > CNT_W'(VC_MAX)) ? VC_W'(VC_MAX) : count_c[VC_W-1:0];

	// State update as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_mode_q     <= MODE_FORWARD;
			turn_finished_q <= 1'b0;
			prev_dev_q      <= 8'sd0;
		end else if (adv_s1) begin
			turn_mode_q     <= turn_mode_d;
			turn_finished_q <= turn_finished_d;
			prev_dev_q      <= prev_dev_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			found_q <= found_c;
			left_q  <= found_c ? left_c  : '0;
			right_q <= found_c ? right_c : '0;
			done_q  <= done_c;
			count_q <= (opcode_s1 == OP_SAMPLE) ? vcount_c : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign track_found = found_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign turn_done   = done_q;
	assign valid_count = count_q;

	// Checks
	`ASSERT_IMPL(a_done_needs_found, out_valid_q && done_q, found_q,
		"turn_done without track_found")
	`ASSERT_IMPL(a_lost_is_quiet, out_valid_q && !found_q,
		left_q == '0 && right_q == '0 && !done_q,
		"non-zero drives with track lost")
	`ASSERT_IMPL(a_found_count, out_valid_q && found_q, count_q > VC_W'(FOUND_MIN),
		"track_found with count of one or less")
	`ASSERT_NEXT(a_done_reverts, adv_s1 && done_c,
		turn_mode_q == MODE_FORWARD && !turn_finished_q,
		"finished turn did not revert to forward")

endmodule

// ----- verif/steer_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the line tracker steering core: follows the register port and both word
// channels, predicts every result word from its own copy of the core state and compares.
// Depends on mltps_pkg.
module steer_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [mltps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mltps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [mltps_pkg::SENSOR_BITS-1:0]    sensor_word,
	input  logic [1:0]                           motion_command,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic                                 track_found,
	input  logic signed [mltps_pkg::DRIVE_W-1:0] left_drive,
	input  logic signed [mltps_pkg::DRIVE_W-1:0] right_drive,
	input  logic                                 turn_done,
	input  logic [mltps_pkg::VC_W-1:0]           valid_count,
	input  logic                                 run_done,
	output int                                   results_seen,
	output int                                   turns_completed,
	output int                                   fail_count
);

	import mltps_pkg::*;

	typedef struct packed {
		logic               track_found;
		logic [DRIVE_W-1:0] left_drive;
		logic [DRIVE_W-1:0] right_drive;
		logic               turn_done;
		logic [VC_W-1:0]    valid_count;
	} steer_word_t;

	// shadow registers
	logic [6:0] speed;
	logic [6:0] ratio;
	logic [3:0] set_point;
	logic [7:0] p_gain;
	logic [7:0] d_gain;

	// shadow core state
	turn_mode_t        mode;
	logic              turn_finished;
	logic signed [7:0] last_dev;

	steer_word_t steer_due_q[$];
	steer_word_t got;
	steer_word_t want;

	initial begin
		fail_count      = 0;
		turns_completed = 0;
	end

	task automatic note_mismatch(input string msg);
		$display("%0t steer mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic signed [DRIVE_W:0] seen,
			input logic signed [DRIVE_W:0] due);
		if (seen !== due)
			note_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, name, seen, due));
	endtask

	// saturate a drive value to the 15-bit signed range
	function automatic logic [DRIVE_W-1:0] clip_drive(input int v);
		int c;
		c = v;
		if (c > DRIVE_MAX)
			c = DRIVE_MAX;
		if (c < DRIVE_MIN)
			c = DRIVE_MIN;
		return c[DRIVE_W-1:0];
	endfunction

	// Steering decision for one accepted word; updates the shadow state
	function automatic steer_word_t steer_from_word(input logic op,
			input logic [SENSOR_BITS-1:0] w, input logic [1:0] cmd);
		steer_word_t       r;
		logic [SENSOR_BITS:0] strip;
		int                i, count, lo, hi, near_pos, best, gap_to_centre, point, vc, diff;
		int                prod, duty_prod;
		logic              in_run, have_near;
		logic signed [7:0] dev, ddev, duty;
		logic signed [15:0] pd;
		r = '0;
		if (op == OP_MOTION) begin
			mode = (cmd == CMD_UNUSED) ? MODE_FORWARD : turn_mode_t'(cmd);
			return r;
		end

		// pair scan; the bit above the strip reads as clear
		strip     = {1'b0, w};
		count     = 0;
		lo        = SENSOR_BITS - 1;
		hi        = 0;
		near_pos  = CENTER_POS;
		best      = 0;
		in_run    = 1'b0;
		have_near = 1'b0;
		for (i = 0; i < SENSOR_BITS; i++) begin
			if (strip[i] && strip[i+1]) begin
				in_run = 1'b1;
				count++;
				if (i > hi)
					hi = i;
				if (i < lo)
					lo = i;
				gap_to_centre = (i < CENTER_POS) ? CENTER_POS - i : i - CENTER_POS;
				if (!have_near || gap_to_centre < best) begin
					near_pos  = i;
					best      = gap_to_centre;
					have_near = 1'b1;
				end
			end else if (in_run) begin
				count++;
				in_run = 1'b0;
			end
		end
		vc            = (count > VC_MAX) ? VC_MAX : count;
		r.valid_count = vc[VC_W-1:0];
		if (count <= FOUND_MIN)
			return r;

		// point choice: wide crossing follows the turn, narrow line ends it
		if (count > TURN_MIN) begin
			turn_finished = 1'b1;
			case (mode)
				MODE_LEFT:  point = hi;
				MODE_RIGHT: point = lo;
				default:    point = near_pos;
			endcase
		end else begin
			if (turn_finished) begin
				turn_finished = 1'b0;
				mode          = MODE_FORWARD;
				r.turn_done   = 1'b1;
			end
			point = near_pos;
		end

		// PD term, only from the minimum speed up
		pd = '0;
		if (speed >= PD_MIN_SPEED) begin
			diff     = int'(set_point) - point;
			dev      = diff[7:0];
			diff     = int'(dev) - int'(last_dev);
			ddev     = diff[7:0];
			last_dev = dev;
			prod     = int'(p_gain) * int'(dev) + int'(d_gain) * int'(ddev);
			pd       = prod[15:0];
		end
		duty_prod     = int'(speed) * int'(ratio);
		duty          = duty_prod[7:0];
		r.track_found = 1'b1;
		r.left_drive  = clip_drive(int'(duty) + int'(pd));
		r.right_drive = clip_drive(int'(duty) - int'(pd));
		return r;
	endfunction

	// Register writes, prediction on input accept, compare on result accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed         = 7'd3;
			ratio         = 7'd1;
			set_point     = 4'd7;
			p_gain        = '0;
			d_gain        = '0;
			mode          = MODE_FORWARD;
			turn_finished = 1'b0;
			last_dev      = '0;
			steer_due_q.delete();
			results_seen <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SPEED: speed     = cfg_data[6:0];
					REG_RATIO: ratio     = cfg_data[6:0];
					REG_SETPT: set_point = cfg_data[3:0];
					REG_PGAIN: p_gain    = cfg_data;
					REG_DGAIN: d_gain    = cfg_data;
					default:   ;
				endcase
			end
			if (in_valid && !in_stall)
				steer_due_q.push_back(steer_from_word(opcode, sensor_word, motion_command));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				got = {track_found, left_drive, right_drive, turn_done, valid_count};
				if (steer_due_q.size() == 0) begin
					note_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
				end else begin
					want = steer_due_q.pop_front();
					if (want.turn_done)
						turns_completed++;
					check_field("track_found", got.track_found, want.track_found);
					check_field("left_drive", $signed(got.left_drive), $signed(want.left_drive));
					check_field("right_drive", $signed(got.right_drive),
						$signed(want.right_drive));
					check_field("turn_done", got.turn_done, want.turn_done);
					check_field("valid_count", got.valid_count, want.valid_count);
				end
			end
		end
	end

	// anything still due at the end never came out
	always @(posedge run_done) begin
		if (steer_due_q.size() != 0)
			note_mismatch($sformatf("%0d expected results never arrived", steer_due_q.size()));
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Top of the steering core testbench: clock, reset, register settings and word traffic.
// Depends on mltps_pkg, the steering core and steer_checker.
module tb;

	import mltps_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int NUM_PHASES      = 7;
	localparam int ITEMS_PER_PHASE = 132;
	localparam int HOLD_CYCLES     = 60;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TIMEOUT_CYCLES  = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       opcode = OP_SAMPLE;
	logic [SENSOR_BITS-1:0]     sensor_word = '0;
	logic [1:0]                 motion_command = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       track_found;
	logic signed [DRIVE_W-1:0]  left_drive;
	logic signed [DRIVE_W-1:0]  right_drive;
	logic                       turn_done;
	logic [VC_W-1:0]            valid_count;
	logic                       run_done = 1'b0;

	int results_seen;
	int turns_completed;
	int fail_count;
	int words_sent = 0;
	int samples_sent = 0;
	int commands_sent = 0;
	int settings_loaded = 0;
	int full_cycles = 0;

	bit idle_on = 1'b1;
	bit hold_arm = 1'b0;
	bit hold_taken = 1'b0;

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	magnetic_line_tracker_pd_steer_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.sensor_word    (sensor_word),
		.motion_command (motion_command),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.track_found    (track_found),
		.left_drive     (left_drive),
		.right_drive    (right_drive),
		.turn_done      (turn_done),
		.valid_count    (valid_count)
	);

	steer_checker steer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.sensor_word     (sensor_word),
		.motion_command  (motion_command),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.track_found     (track_found),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.turn_done       (turn_done),
		.valid_count     (valid_count),
		.run_done        (run_done),
		.results_seen    (results_seen),
		.turns_completed (turns_completed),
		.fail_count      (fail_count)
	);

	// cycles in which the core refused an offered word
	always @(posedge clk) begin
		if (in_valid && in_stall)
			full_cycles++;
	end

	// Result side: one long hold-off when armed, else short random stall bursts while idle_on
	initial begin
		forever begin
			@(posedge clk);
			if (hold_arm && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Write all five registers plus one unused index; upper data bits carry junk
	task automatic load_setting(input logic [6:0] spd, input logic [6:0] rat,
			input logic [3:0] sp, input logic [7:0] pg, input logic [7:0] dg);
		logic [7:0]           junk;
		logic [CFG_IDX_W-1:0] spare;
		junk  = 8'($urandom);
		spare = CFG_IDX_W'(int'(REG_DGAIN) + $urandom_range(1, 3));
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_SPEED;
		cfg_data     <= {junk[7], spd};
		@(posedge clk);
		cfg_index    <= REG_RATIO;
		cfg_data     <= {junk[6], rat};
		@(posedge clk);
		cfg_index    <= REG_SETPT;
		cfg_data     <= {junk[7:4], sp};
		@(posedge clk);
		cfg_index    <= REG_PGAIN;
		cfg_data     <= pg;
		@(posedge clk);
		cfg_index    <= REG_DGAIN;
		cfg_data     <= dg;
		@(posedge clk);
		cfg_index    <= spare;
		cfg_data     <= junk;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		settings_loaded++;
	endtask

	// Offer one word, with an occasional gap first, and hold it until taken
	task automatic send_word(input opcode_t op, input logic [SENSOR_BITS-1:0] w,
			input logic [1:0] cmd);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		opcode         <= op;
		sensor_word    <= w;
		motion_command <= cmd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (op == OP_SAMPLE)
			samples_sent++;
		else
			commands_sent++;
	endtask

	task automatic send_sample(input logic [SENSOR_BITS-1:0] w);
		send_word(OP_SAMPLE, w, 2'($urandom_range(0, 3)));
	endtask

	task automatic send_command(input logic [1:0] cmd);
		send_word(OP_MOTION, SENSOR_BITS'($urandom), cmd);
	endtask

	// wait until every word offered so far has come back out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_seen != words_sent)
			@(posedge clk);
	endtask

	// several short runs of set bits: a junction, count above the turn threshold
	function automatic logic [SENSOR_BITS-1:0] multi_run_word();
		logic [SENSOR_BITS-1:0] w;
		int pos, len, b;
		w   = '0;
		pos = $urandom_range(0, 2);
		while (pos < SENSOR_BITS - 1) begin
			len = $urandom_range(2, 4);
			for (b = pos; b < pos + len && b < SENSOR_BITS; b++)
				w[b] = 1'b1;
			pos += len + $urandom_range(1, 2);
		end
		return w;
	endfunction

	// one run of 2 to 5 set bits: a plain line, count 2 to 5
	function automatic logic [SENSOR_BITS-1:0] single_run_word();
		logic [SENSOR_BITS-1:0] w;
		int s, len, b;
		w   = '0;
		s   = $urandom_range(0, SENSOR_BITS - 2);
		len = $urandom_range(2, (SENSOR_BITS - s < 5) ? SENSOR_BITS - s : 5);
		for (b = s; b < s + len; b++)
			w[b] = 1'b1;
		return w;
	endfunction

	// Random traffic: mostly complete turns, with noise words and stray commands
	task automatic run_traffic(input int n);
		int                     start;
		logic [SENSOR_BITS-1:0] w;
		start = words_sent;
		while (words_sent - start < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					send_command($urandom_range(0, 1) ? MODE_RIGHT : MODE_LEFT);
					repeat ($urandom_range(1, 5)) send_sample(multi_run_word());
					repeat ($urandom_range(1, 3)) send_sample(single_run_word());
				end
				5: begin
					// junction met while going forward
					send_command($urandom_range(0, 1) ? MODE_FORWARD : CMD_UNUSED);
					repeat ($urandom_range(1, 3)) send_sample(multi_run_word());
					send_sample(single_run_word());
				end
				6, 7: begin
					repeat ($urandom_range(1, 4)) send_sample(SENSOR_BITS'($urandom));
				end
				8: begin
					w = SENSOR_BITS'($urandom);
					case ($urandom_range(0, 2))
						0:       w = '0;
						1:       w = '1;
						default: w = w & ($urandom_range(0, 1) ? 16'h5555 : 16'hAAAA);
					endcase
					send_sample(w);
				end
				default: send_command(2'($urandom_range(0, 3)));
			endcase
		end
	endtask

	// Stimulus and verdict
	initial begin
		int phase;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: strip extremes, nearest-point tie, each turn mode and its completion
		load_setting(7'd25, 7'd5, 4'd7, 8'd30, 8'd10);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0180);
		send_sample(16'h0001);
		send_sample(16'h0003);
		send_sample(16'hC000);
		send_sample(16'h8000);
		send_sample(16'h0660);
		send_command(MODE_LEFT);
		send_sample(16'h3333);
		send_sample(16'h3333);
		send_sample(16'h0300);
		send_command(MODE_RIGHT);
		send_sample(16'hCCCC);
		send_sample(16'h0018);
		send_command(MODE_FORWARD);
		send_sample(16'h3333);
		send_sample(16'h0030);
		send_command(CMD_UNUSED);
		send_sample(16'hFFFF);
		send_sample(16'h7FFE);
		send_sample(16'hAAAA);
		send_sample(16'h5555);
		wait_drained();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: load_setting(7'd3, 7'd1, 4'd7, 8'd0, 8'd0);
				1: load_setting(7'd10, 7'd12, 4'd7, 8'd40, 8'd9);
				2: load_setting(7'd127, 7'd127, 4'd15, 8'd255, 8'd255);
				3: load_setting(7'd9, 7'd127, 4'd0, 8'd255, 8'd255);
				4: load_setting(7'd0, 7'd0, 4'd0, 8'd0, 8'd0);
				5: load_setting(7'($urandom_range(10, 127)), 7'($urandom_range(0, 127)),
					4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: load_setting(7'd64, 7'd2, 4'd3, 8'd200, 8'd17);
			endcase
			// no idling in the closing phase; long hold-off early on
			idle_on = (phase < NUM_PHASES - 1);
			if (phase == 1)
				hold_arm = 1'b1;
			run_traffic(ITEMS_PER_PHASE);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Covered %0d words (%0d sensor samples, %0d motion commands) over %0d settings;",
			words_sent, samples_sent, commands_sent, settings_loaded);
		$display("%0d completed turns, input held back by a full core for %0d cycles.",
			turns_completed, full_cycles);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d of %0d results back", results_seen, words_sent);
		$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mltps_pkg.sv
sv/magnetic_line_tracker_pd_steer_core.sv
verif/steer_checker.sv
verif/tb.sv
